// ===== design/sph_pkg.sv =====
// Shared types and constants for the SOCKS handshake parser.
// Used by sph_front, sph_queue, sph_back and the top level.
`default_nettype none

package sph_pkg;

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_START   = 2'd1,
    OP_OUTCOME = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_REPLY = 2'd0,
    KIND_ADDR  = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_CLOSE = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    RSN_NONE     = 3'd0,
    RSN_BAD_VER  = 3'd1,
    RSN_NO_METH  = 3'd2,
    RSN_BAD_AUTH = 3'd3,
    RSN_REJECTED = 3'd4,
    RSN_CONN_ERR = 3'd5
  } reason_e;

  typedef enum logic [2:0] {
    R_CLOSE = 3'd0,
    R_BYTE2 = 3'd1,
    R_ADDR  = 3'd2,
    R_DONE  = 3'd3,
    R_V5    = 3'd4,
    R_V4    = 3'd5
  } run_e;

  localparam logic [7:0] VER5        = 8'h05;
  localparam logic [7:0] VER4        = 8'h04;
  localparam logic [7:0] METH_NOAUTH = 8'h00;
  localparam logic [7:0] METH_USERPW = 8'h02;
  localparam logic [7:0] METH_NONE   = 8'hFF;
  localparam logic [7:0] AUTH_VER    = 8'h01;
  localparam logic [7:0] CMD_CONNECT = 8'h01;
  localparam logic [7:0] ATYP_IPV4   = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN = 8'h03;
  localparam logic [7:0] ATYP_IPV6   = 8'h04;
  localparam logic [7:0] REP_OK      = 8'h00;
  localparam logic [7:0] REP_GENERAL = 8'h02;
  localparam logic [7:0] REP_HOST    = 8'h04;
  localparam logic [7:0] REP_CMD     = 8'h07;
  localparam logic [7:0] REP_ATYP    = 8'h08;
  localparam logic [7:0] V4_GRANTED  = 8'd90;
  localparam logic [7:0] V4_FAILED   = 8'd91;

  localparam logic [1:0] AT_IPV4   = 2'd0;
  localparam logic [1:0] AT_DOMAIN = 2'd1;
  localparam logic [1:0] AT_IPV6   = 2'd2;

  typedef struct packed {
    run_e        rtype;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [31:0] ip;
    logic [15:0] port;
    logic [1:0]  atype;
    logic        v4;
    reason_e     reason;
  } desc_t;

  function automatic logic [3:0] run_len(run_e r);
    logic [3:0] n;
    unique case (r)
      R_CLOSE: n = 4'd1;
      R_BYTE2: n = 4'd2;
      R_ADDR:  n = 4'd1;
      R_DONE:  n = 4'd1;
      R_V5:    n = 4'd10;
      R_V4:    n = 4'd8;
      default: n = 4'd1;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== design/sph_front.sv =====
// Handshake parser front end: walks the session state one request at a time
// and emits one run descriptor per request that produces results. Uses sph_pkg.
`default_nettype none

module sph_front #(
  parameter int MaxV4Request = 256
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          acc_i,
  input  wire logic [1:0]    opcode_i,
  input  wire logic [7:0]    client_byte_i,
  input  wire logic          connect_ok_i,
  input  wire logic [31:0]   bound_ipv4_i,
  input  wire logic [15:0]   bound_port_i,
  input  wire logic          bound_is_v4_i,
  output logic               push_o,
  output sph_pkg::desc_t     desc_o
);
  import sph_pkg::*;

  typedef enum logic [13:0] {
    PH_VER        = 14'b00000000000001,
    PH_GREET      = 14'b00000000000010,
    PH_AUTH_HEAD  = 14'b00000000000100,
    PH_AUTH_ID    = 14'b00000000001000,
    PH_AUTH_PWLEN = 14'b00000000010000,
    PH_AUTH_PW    = 14'b00000000100000,
    PH_REQ_HEAD   = 14'b00000001000000,
    PH_REQ_DLEN   = 14'b00000010000000,
    PH_REQ_ADDR   = 14'b00000100000000,
    PH_REQ_PORT   = 14'b00001000000000,
    PH_V4_REQ     = 14'b00010000000000,
    PH_WAIT_OUT   = 14'b00100000000000,
    PH_OPEN       = 14'b01000000000000,
    PH_CLOSED     = 14'b10000000000000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [8:0]  cnt_q, cnt_d;
  logic [1:0]  mflags_q, mflags_d;
  logic [7:0]  flen_q, flen_d;
  logic [7:0]  pwlen_q, pwlen_d;
  logic [1:0]  atype_q, atype_d;
  logic [15:0] port_q, port_d;
  logic        v4_q, v4_d;

  always_comb begin
    logic [7:0]  b;
    logic        v4_done;
    logic [31:0] addr;
    b       = client_byte_i;
    v4_done = 1'b0;
    addr    = bound_is_v4_i ? bound_ipv4_i : 32'd0;
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    mflags_d = mflags_q;
    flen_d   = flen_q;
    pwlen_d  = pwlen_q;
    atype_d  = atype_q;
    port_d   = port_q;
    v4_d     = v4_q;
    push_o   = 1'b0;
    desc_o   = '0;
    if (acc_i) begin
      unique case (opcode_i)
        OP_BYTE: begin
          unique case (phase_q)
            PH_VER: begin
              cnt_d = 9'd1;
              if (b == VER5) begin
                phase_d = PH_GREET;
                v4_d    = 1'b0;
              end else if (b == VER4) begin
                phase_d = PH_V4_REQ;
                v4_d    = 1'b1;
                atype_d = AT_IPV4;
                port_d  = '0;
              end else begin
                phase_d = PH_CLOSED;
                push_o  = 1'b1;
                desc_o.rtype  = R_CLOSE;
                desc_o.reason = RSN_BAD_VER;
              end
            end
            PH_GREET: begin
              if (cnt_q == 9'd1) begin
                cnt_d    = 9'd2;
                flen_d   = b;
                mflags_d = 2'b00;
              end else begin
                mflags_d = mflags_q | {b == METH_USERPW, b == METH_NOAUTH};
                flen_d   = flen_q - 8'd1;
              end
              if (flen_d == 8'd0) begin
                push_o       = 1'b1;
                desc_o.rtype = R_BYTE2;
                desc_o.b0    = VER5;
                cnt_d        = 9'd0;
                if (mflags_d[1]) begin
                  desc_o.b1 = METH_USERPW;
                  phase_d   = PH_AUTH_HEAD;
                end else if (mflags_d[0]) begin
                  desc_o.b1 = METH_NOAUTH;
                  phase_d   = PH_REQ_HEAD;
                end else begin
                  desc_o.b1     = METH_NONE;
                  desc_o.reason = RSN_NO_METH;
                  phase_d       = PH_CLOSED;
                  cnt_d         = cnt_q == 9'd1 ? 9'd2 : cnt_q;
                end
              end
            end
            PH_AUTH_HEAD: begin
              if (cnt_q == 9'd0) begin
                if (b != AUTH_VER) begin
                  phase_d       = PH_CLOSED;
                  push_o        = 1'b1;
                  desc_o.rtype  = R_CLOSE;
                  desc_o.reason = RSN_BAD_AUTH;
                end else begin
                  cnt_d = 9'd1;
                end
              end else begin
                flen_d  = b;
                phase_d = (b == 8'd0) ? PH_AUTH_PWLEN : PH_AUTH_ID;
              end
            end
            PH_AUTH_ID: begin
              flen_d = flen_q - 8'd1;
              if (flen_d == 8'd0) phase_d = PH_AUTH_PWLEN;
            end
            PH_AUTH_PWLEN, PH_AUTH_PW: begin
              pwlen_d = (phase_q == PH_AUTH_PWLEN) ? b : pwlen_q - 8'd1;
              if (pwlen_d == 8'd0) begin
                push_o       = 1'b1;
                desc_o.rtype = R_BYTE2;
                desc_o.b0    = AUTH_VER;
                desc_o.b1    = 8'h00;
                phase_d      = PH_REQ_HEAD;
                cnt_d        = 9'd0;
              end else begin
                phase_d = PH_AUTH_PW;
              end
            end
            PH_REQ_HEAD: begin
              desc_o.rtype  = R_V5;
              desc_o.reason = RSN_REJECTED;
              if (cnt_q == 9'd0 && b != VER5) begin
                push_o = 1'b1;
                desc_o.b1 = REP_GENERAL;
              end else if (cnt_q == 9'd1 && b != CMD_CONNECT) begin
                push_o = 1'b1;
                desc_o.b1 = REP_CMD;
              end else if (cnt_q == 9'd2 && b != 8'h00) begin
                push_o = 1'b1;
                desc_o.b1 = REP_GENERAL;
              end else if (cnt_q >= 9'd3) begin
                if (b == ATYP_IPV4) begin
                  atype_d = AT_IPV4;
                  flen_d  = 8'd4;
                  phase_d = PH_REQ_ADDR;
                end else if (b == ATYP_DOMAIN) begin
                  atype_d = AT_DOMAIN;
                  phase_d = PH_REQ_DLEN;
                end else if (b == ATYP_IPV6) begin
                  atype_d = AT_IPV6;
                  flen_d  = 8'd16;
                  phase_d = PH_REQ_ADDR;
                end else begin
                  push_o = 1'b1;
                  desc_o.b1 = REP_ATYP;
                end
              end else begin
                cnt_d = cnt_q + 9'd1;
              end
              if (push_o) phase_d = PH_CLOSED;
            end
            PH_REQ_DLEN: begin
              flen_d = b;
              if (b == 8'd0) begin
                phase_d = PH_REQ_PORT;
                cnt_d   = 9'd0;
                port_d  = '0;
              end else begin
                phase_d = PH_REQ_ADDR;
              end
            end
            PH_REQ_ADDR: begin
              push_o       = 1'b1;
              desc_o.rtype = R_ADDR;
              desc_o.b0    = b;
              flen_d       = flen_q - 8'd1;
              if (flen_d == 8'd0) begin
                phase_d = PH_REQ_PORT;
                cnt_d   = 9'd0;
                port_d  = '0;
              end
            end
            PH_REQ_PORT: begin
              port_d = {port_q[7:0], b};
              cnt_d  = cnt_q + 9'd1;
              if (cnt_d >= 9'd2) begin
                push_o       = 1'b1;
                desc_o.rtype = R_DONE;
                phase_d      = PH_WAIT_OUT;
              end
            end
            PH_V4_REQ: begin
              if (cnt_q == 9'd1 && b != CMD_CONNECT) begin
                push_o        = 1'b1;
                desc_o.rtype  = R_V4;
                desc_o.b1     = V4_FAILED;
                desc_o.reason = RSN_REJECTED;
                phase_d       = PH_CLOSED;
              end else begin
                if (cnt_q == 9'd2 || cnt_q == 9'd3) begin
                  port_d = {port_q[7:0], b};
                end else if (cnt_q >= 9'd4 && cnt_q <= 9'd7) begin
                  push_o       = 1'b1;
                  desc_o.rtype = R_ADDR;
                  desc_o.b0    = b;
                end else if (cnt_q >= 9'd8 && b == 8'd0) begin
                  v4_done = 1'b1;
                end
                cnt_d = cnt_q + 9'd1;
                if (v4_done || {1'b0, cnt_d} >= 10'(MaxV4Request)) begin
                  push_o       = 1'b1;
                  desc_o.rtype = R_DONE;
                  phase_d      = PH_WAIT_OUT;
                end
              end
            end
            default: ;
          endcase
        end
        OP_START: begin
          phase_d  = PH_VER;
          cnt_d    = '0;
          mflags_d = '0;
          flen_d   = '0;
          pwlen_d  = '0;
          atype_d  = '0;
          port_d   = '0;
          v4_d     = 1'b0;
        end
        OP_OUTCOME: begin
          if (phase_q == PH_WAIT_OUT) begin
            push_o       = 1'b1;
            desc_o.rtype = v4_q ? R_V4 : R_V5;
            if (connect_ok_i) begin
              desc_o.b1   = v4_q ? V4_GRANTED : REP_OK;
              desc_o.ip   = addr;
              desc_o.port = bound_port_i;
              phase_d     = PH_OPEN;
            end else begin
              desc_o.b1     = v4_q ? V4_FAILED : REP_HOST;
              desc_o.reason = RSN_CONN_ERR;
              phase_d       = PH_CLOSED;
            end
          end
        end
        default: ;
      endcase
    end
    desc_o.v4 = v4_d;
    if (desc_o.rtype == R_ADDR || desc_o.rtype == R_DONE) desc_o.atype = atype_d;
    if (desc_o.rtype == R_DONE) desc_o.port = port_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_VER;
      cnt_q    <= '0;
      mflags_q <= '0;
      flen_q   <= '0;
      pwlen_q  <= '0;
      atype_q  <= '0;
      port_q   <= '0;
      v4_q     <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      mflags_q <= mflags_d;
      flen_q   <= flen_d;
      pwlen_q  <= pwlen_d;
      atype_q  <= atype_d;
      port_q   <= port_d;
      v4_q     <= v4_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/sph_queue.sv =====
// Small descriptor queue between the parser front end and the reply
// serializer. Uses sph_pkg for the descriptor type.
`default_nettype none

module sph_queue #(
  parameter int Depth = 4
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  sph_pkg::desc_t wdata_i,
  input  wire logic      pop_i,
  output sph_pkg::desc_t rdata_o,
  output logic           empty_o,
  output logic           full_o
);
  import sph_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  desc_t           mem_q [Depth];
  logic [AW-1:0]   wptr_q, rptr_q;
  logic [AW:0]     cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= (wptr_q == AW'(Depth - 1)) ? '0 : wptr_q + AW'(1);
      if (pop_i)  rptr_q <= (rptr_q == AW'(Depth - 1)) ? '0 : rptr_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue pop while empty");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> cnt_q == $past(cnt_q) + (AW+1)'($past(push_i)) - (AW+1)'($past(pop_i)))
    else $error("queue count mismatch");

endmodule

`default_nettype wire

// ===== design/sph_back.sv =====
// Reply serializer: expands each run descriptor into its result items,
// one per cycle while the receiver is ready, into an output register. Uses sph_pkg.
`default_nettype none

module sph_back (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  sph_pkg::desc_t  head_i,
  input  wire logic       empty_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      out_kind_o,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      target_addr_type_o,
  output logic [15:0]     target_port_o,
  output logic            is_v4_request_o,
  output logic [2:0]      close_reason_o,
  output logic            last_o
);
  import sph_pkg::*;

  logic [3:0]  idx_q, idx_d;
  logic        valid_q;
  logic        load;
  logic        is_last;
  kind_e       kind;
  logic [7:0]  obyte;
  logic [1:0]  atype;
  logic [15:0] port;

  assign is_last = (idx_q == run_len(head_i.rtype) - 4'd1);
  assign load    = !empty_i && (!valid_q || out_ready_i);
  assign pop_o   = load && is_last;
  assign idx_d   = is_last ? 4'd0 : idx_q + 4'd1;

  always_comb begin
    kind  = KIND_REPLY;
    obyte = 8'h00;
    atype = AT_IPV4;
    port  = '0;
    unique case (head_i.rtype)
      R_CLOSE: kind = KIND_CLOSE;
      R_BYTE2: obyte = (idx_q == 4'd0) ? head_i.b0 : head_i.b1;
      R_ADDR: begin
        kind  = KIND_ADDR;
        obyte = head_i.b0;
        atype = head_i.atype;
      end
      R_DONE: begin
        kind  = KIND_DONE;
        atype = head_i.atype;
        port  = head_i.port;
      end
      R_V5: begin
        unique case (idx_q)
          4'd0:    obyte = VER5;
          4'd1:    obyte = head_i.b1;
          4'd2:    obyte = 8'h00;
          4'd3:    obyte = ATYP_IPV4;
          4'd4:    obyte = head_i.ip[31:24];
          4'd5:    obyte = head_i.ip[23:16];
          4'd6:    obyte = head_i.ip[15:8];
          4'd7:    obyte = head_i.ip[7:0];
          4'd8:    obyte = head_i.port[15:8];
          default: obyte = head_i.port[7:0];
        endcase
      end
      R_V4: begin
        unique case (idx_q)
          4'd0:    obyte = 8'h00;
          4'd1:    obyte = head_i.b1;
          4'd2:    obyte = head_i.port[15:8];
          4'd3:    obyte = head_i.port[7:0];
          4'd4:    obyte = head_i.ip[31:24];
          4'd5:    obyte = head_i.ip[23:16];
          4'd6:    obyte = head_i.ip[15:8];
          default: obyte = head_i.ip[7:0];
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) idx_q <= idx_d;
      if (load) valid_q <= 1'b1;
      else if (out_ready_i) valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_kind_o         <= kind;
      out_byte_o         <= obyte;
      target_addr_type_o <= atype;
      target_port_o      <= port;
      is_v4_request_o    <= head_i.v4;
      close_reason_o     <= head_i.reason;
      last_o             <= is_last;
    end
  end

  assign out_valid_o = valid_q;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> idx_q < run_len(head_i.rtype)) else $error("run index out of range");
  a_idx_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> idx_q == 4'd0) else $error("run index not cleared after pop");
  a_last_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_o && last_o) else $error("final item not flagged");

endmodule

`default_nettype wire

// ===== design/socks_proxy_handshake_parser.sv =====
// Top level of the SOCKS4/SOCKS5 server handshake parser.
// Instantiates sph_front, sph_queue and sph_back; uses sph_pkg.
//
// Usage: each input request carries an opcode (client byte, new session or
// connect outcome) with its payload on a valid/ready channel. Each request
// yields zero to ten result items on the output valid/ready channel, the
// final one of a request marked by last_o.
// The parser takes one request per cycle while input ready is high; results
// leave one per cycle while the receiver is ready. An accepted request's
// descriptor is registered in the run queue and then in the output register.
// The parser and the serializer are joined by a four-entry run queue; input
// ready drops only while that queue is full, which happens when the
// receiver stalls or several long replies are waiting.
// Reset clears the session to await a version byte and empties the queue
// and output register; a start request does the same to the session alone.
`default_nettype none

module socks_proxy_handshake_parser #(
  parameter int MaxV4Request = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [7:0]  client_byte_i,
  input  wire logic        connect_ok_i,
  input  wire logic [31:0] bound_ipv4_i,
  input  wire logic [15:0] bound_port_i,
  input  wire logic        bound_is_v4_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       out_kind_o,
  output logic [7:0]       out_byte_o,
  output logic [1:0]       target_addr_type_o,
  output logic [15:0]      target_port_o,
  output logic             is_v4_request_o,
  output logic [2:0]       close_reason_o,
  output logic             last_o
);
  import sph_pkg::*;

  logic  push, pop, empty, full, acc;
  desc_t wdesc, head;

  assign in_ready_o = !full;
  assign acc        = in_valid_i && !full;

  sph_front #(.MaxV4Request(MaxV4Request)) u_front (
    .clk_i, .rst_ni,
    .acc_i(acc),
    .opcode_i, .client_byte_i, .connect_ok_i,
    .bound_ipv4_i, .bound_port_i, .bound_is_v4_i,
    .push_o(push),
    .desc_o(wdesc)
  );

  sph_queue #(.Depth(4)) u_queue (
    .clk_i, .rst_ni,
    .push_i(push),
    .wdata_i(wdesc),
    .pop_i(pop),
    .rdata_o(head),
    .empty_o(empty),
    .full_o(full)
  );

  sph_back u_back (
    .clk_i, .rst_ni,
    .head_i(head),
    .empty_i(empty),
    .pop_o(pop),
    .out_valid_o, .out_ready_i,
    .out_kind_o, .out_byte_o, .target_addr_type_o, .target_port_o,
    .is_v4_request_o, .close_reason_o, .last_o
  );

endmodule

`default_nettype wire
